FILE: rtl/bbc_pkg.sv
// Package for the block buffer cache tag manager: sizes, codes and record types.
// Used by the RTL files other than bbc_ram, and by the checker; depends on nothing.
`default_nettype none

package bbc_pkg;

	localparam int NUM_ENTRIES = 32;
	localparam int NUM_BUCKETS = 13;

	localparam int OP_W     = 2;
	localparam int DEV_W    = 8;
	localparam int BLK_W    = 32;
	localparam int IDX_W    = 5;
	localparam int TIME_W   = 32;
	localparam int CNT_W    = 8;
	localparam int STATUS_W = 2;

	localparam int ADDR_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam int MOD_STEP_BITS = 8;

	typedef enum logic [OP_W-1:0] {
		OP_GET     = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_UNPIN   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_FREE   = 2'd1,
		STAT_COUNT_ERR = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_SCAN,
		S_PICK,
		S_FETCH,
		S_UPDATE,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic [DEV_W-1:0]  dev;
		logic [BLK_W-1:0]  blk;
		logic [BKT_W-1:0]  bkt;
		logic              valid;
		logic [CNT_W-1:0]  cnt;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic             done;
		logic [BKT_W-1:0] bucket;
	} mod_stat_t;

endpackage

`default_nettype wire

FILE: rtl/bbc_req_if.sv
// Request channel of the buffer cache tag manager: valid/ready plus request fields.
// Depends on bbc_pkg for field widths.
`default_nettype none

interface bbc_req_if;
	logic                         valid;
	logic                         ready;
	logic [bbc_pkg::OP_W-1:0]     op;
	logic [bbc_pkg::DEV_W-1:0]    device_id;
	logic [bbc_pkg::BLK_W-1:0]    block_number;
	logic [bbc_pkg::IDX_W-1:0]    entry_index;
	logic [bbc_pkg::TIME_W-1:0]   now_ticks;

	modport source (
		output valid, op, device_id, block_number, entry_index, now_ticks,
		input  ready
	);

	modport sink (
		input  valid, op, device_id, block_number, entry_index, now_ticks,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/bbc_rsp_if.sv
// Response channel of the buffer cache tag manager: valid/ready plus result fields.
// Depends on bbc_pkg for field widths.
`default_nettype none

interface bbc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [bbc_pkg::IDX_W-1:0]      entry_out;
	logic                           was_hit;
	logic                           needs_read;
	logic [bbc_pkg::STATUS_W-1:0]   status;

	modport source (
		output valid, entry_out, was_hit, needs_read, status,
		input  ready
	);

	modport sink (
		input  valid, entry_out, was_hit, needs_read, status,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/block_buffer_cache_tags.sv
// Top level of the block buffer cache tag manager: controller, entry RAM, hash unit.
// Depends on bbc_pkg, bbc_req_if, bbc_rsp_if, bbc_ram and bbc_mod.
//
// channel  dir  handshake           carries
// req      in   req.valid/ready     op, device_id, block_number, entry_index, now_ticks
// rsp      out  rsp.valid/ready     entry_out, was_hit, needs_read, status
//
// One item at a time. A get runs the bucket hash (8 bits a cycle), a scan of all
// entries through the RAM read port, then pick, fetch, update and output; without a
// free entry it skips fetch and update. Release, pin and unpin fetch, update, output.
// Reset clears all entries at once through per-entry written flags; no sweep.
// A waiting result sits in the output register; a new item is taken meanwhile
// and stalls only at its own output step.
`default_nettype none

module block_buffer_cache_tags (
	input  logic       clk,
	input  logic       arst_n,
	bbc_req_if.sink    req,
	bbc_rsp_if.source  rsp
);

	localparam int AW = bbc_pkg::ADDR_W;
	localparam int EW = $bits(bbc_pkg::entry_t);
	localparam logic [AW:0]   SCAN_END = (AW + 1)'(bbc_pkg::NUM_ENTRIES);
	localparam logic [AW-1:0] LAST     = AW'(bbc_pkg::NUM_ENTRIES - 1);

	bbc_pkg::fsm_t state_q, state_d;

	bbc_pkg::op_t                  op_q;
	logic [bbc_pkg::DEV_W-1:0]     dev_q;
	logic [bbc_pkg::BLK_W-1:0]     blk_q;
	logic [bbc_pkg::TIME_W-1:0]    now_q;
	logic [bbc_pkg::BKT_W-1:0]     bkt_q;

	logic [AW:0]                   scan_q;
	logic                          rd_vld_s1;
	logic [AW-1:0]                 rd_addr_s1;

	logic                          hit_found_q;
	logic [AW-1:0]                 hit_idx_q;
	logic                          bb_found_q;
	logic [AW-1:0]                 bb_idx_q;
	logic [bbc_pkg::TIME_W-1:0]    bb_time_q;
	logic                          ab_found_q;
	logic [AW-1:0]                 ab_idx_q;
	logic [bbc_pkg::TIME_W-1:0]    ab_time_q;

	logic [AW-1:0]                 sel_q;
	logic                          sel_hit_q;

	logic [bbc_pkg::IDX_W-1:0]     res_entry_q;
	logic                          res_hit_q;
	logic                          res_need_q;
	bbc_pkg::status_t              res_status_q;

	logic                          rsp_valid_q;
	logic [bbc_pkg::IDX_W-1:0]     rsp_entry_q;
	logic                          rsp_hit_q;
	logic                          rsp_need_q;
	bbc_pkg::status_t              rsp_status_q;

	logic [bbc_pkg::NUM_ENTRIES-1:0] written_q;

	logic                          accept;
	logic                          in_range;
	logic                          scan_issue;
	logic                          mod_start;
	logic                          ram_we;
	logic                          out_load;
	logic [AW-1:0]                 ram_raddr;
	logic [EW-1:0]                 ram_rdata;
	bbc_pkg::entry_t               rec;
	bbc_pkg::entry_t               wrec;
	bbc_pkg::status_t              u_status;
	logic                          u_hit;
	logic                          u_need;
	bbc_pkg::mod_stat_t            mod_stat;

	assign req.ready  = (state_q == bbc_pkg::S_IDLE);
	assign accept     = req.valid && (state_q == bbc_pkg::S_IDLE);
	assign in_range   = int'(req.entry_index) < bbc_pkg::NUM_ENTRIES;
	assign scan_issue = (state_q == bbc_pkg::S_SCAN) && (scan_q < SCAN_END);
	assign ram_raddr  = (state_q == bbc_pkg::S_SCAN) ? scan_q[AW-1:0] : sel_q;
	assign rec        = written_q[rd_addr_s1] ? bbc_pkg::entry_t'(ram_rdata) : '0;

	bbc_ram #(
		.WIDTH (EW),
		.DEPTH (bbc_pkg::NUM_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sel_q),
		.wdata (wrec),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bbc_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (req.block_number),
		.stat   (mod_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mod_start = 1'b0;
		ram_we    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			bbc_pkg::S_IDLE: begin
				if (req.valid) begin
					if (bbc_pkg::op_t'(req.op) == bbc_pkg::OP_GET) begin
						mod_start = 1'b1;
						state_d   = bbc_pkg::S_HASH;
					end else if (in_range) begin
						state_d = bbc_pkg::S_FETCH;
					end else begin
						state_d = bbc_pkg::S_OUT;
					end
				end
			end
			bbc_pkg::S_HASH: begin
				if (mod_stat.done) begin
					state_d = bbc_pkg::S_SCAN;
				end
			end
			bbc_pkg::S_SCAN: begin
				if (rd_vld_s1 && rd_addr_s1 == LAST) begin
					state_d = bbc_pkg::S_PICK;
				end
			end
			bbc_pkg::S_PICK: begin
				if (hit_found_q || bb_found_q || ab_found_q) begin
					state_d = bbc_pkg::S_FETCH;
				end else begin
					state_d = bbc_pkg::S_OUT;
				end
			end
			bbc_pkg::S_FETCH: begin
				state_d = bbc_pkg::S_UPDATE;
			end
			bbc_pkg::S_UPDATE: begin
				ram_we  = 1'b1;
				state_d = bbc_pkg::S_OUT;
			end
			bbc_pkg::S_OUT: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = bbc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bbc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		wrec     = rec;
		u_status = bbc_pkg::STAT_OK;
		u_hit    = 1'b0;
		u_need   = 1'b0;
		case (op_q)
			bbc_pkg::OP_GET: begin
				if (sel_hit_q) begin
					u_hit  = 1'b1;
					u_need = !rec.valid;
					if (rec.cnt == bbc_pkg::COUNT_MAX) begin
						u_status = bbc_pkg::STAT_COUNT_ERR;
					end else begin
						wrec.cnt = rec.cnt + 1'b1;
					end
				end else begin
					u_need   = 1'b1;
					wrec.dev = dev_q;
					wrec.blk = blk_q;
					wrec.bkt = bkt_q;
					wrec.cnt = bbc_pkg::CNT_W'(1);
				end
				wrec.valid = 1'b1;
			end
			bbc_pkg::OP_PIN: begin
				if (rec.cnt == bbc_pkg::COUNT_MAX) begin
					u_status = bbc_pkg::STAT_COUNT_ERR;
				end else begin
					wrec.cnt = rec.cnt + 1'b1;
				end
			end
			bbc_pkg::OP_RELEASE, bbc_pkg::OP_UNPIN: begin
				if (rec.cnt == '0) begin
					u_status = bbc_pkg::STAT_COUNT_ERR;
				end else begin
					wrec.cnt = rec.cnt - 1'b1;
					if (op_q == bbc_pkg::OP_RELEASE && rec.cnt == bbc_pkg::CNT_W'(1)) begin
						wrec.stamp = now_q;
					end
				end
			end
			default: begin
				wrec = rec;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= bbc_pkg::OP_GET;
			dev_q      <= '0;
			blk_q      <= '0;
			now_q      <= '0;
			bkt_q      <= '0;
			scan_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_addr_s1 <= '0;
			written_q  <= '0;
		end else begin
			rd_vld_s1  <= scan_issue;
			rd_addr_s1 <= ram_raddr;
			if (accept) begin
				op_q   <= bbc_pkg::op_t'(req.op);
				dev_q  <= req.device_id;
				blk_q  <= req.block_number;
				now_q  <= req.now_ticks;
				scan_q <= '0;
			end
			if (state_q == bbc_pkg::S_HASH && mod_stat.done) begin
				bkt_q <= mod_stat.bucket;
			end
			if (scan_issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (ram_we) begin
				written_q[sel_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q <= 1'b0;
			hit_idx_q   <= '0;
			bb_found_q  <= 1'b0;
			bb_idx_q    <= '0;
			bb_time_q   <= '0;
			ab_found_q  <= 1'b0;
			ab_idx_q    <= '0;
			ab_time_q   <= '0;
		end else if (accept) begin
			hit_found_q <= 1'b0;
			bb_found_q  <= 1'b0;
			ab_found_q  <= 1'b0;
		end else if (state_q == bbc_pkg::S_SCAN && rd_vld_s1) begin
			if (!hit_found_q && rec.dev == dev_q && rec.blk == blk_q) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= rd_addr_s1;
			end
			if (rec.cnt == '0) begin
				if (rec.bkt == bkt_q && (!bb_found_q || rec.stamp < bb_time_q)) begin
					bb_found_q <= 1'b1;
					bb_idx_q   <= rd_addr_s1;
					bb_time_q  <= rec.stamp;
				end
				if (!ab_found_q || rec.stamp < ab_time_q) begin
					ab_found_q <= 1'b1;
					ab_idx_q   <= rd_addr_s1;
					ab_time_q  <= rec.stamp;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q        <= '0;
			sel_hit_q    <= 1'b0;
			res_entry_q  <= '0;
			res_hit_q    <= 1'b0;
			res_need_q   <= 1'b0;
			res_status_q <= bbc_pkg::STAT_OK;
		end else begin
			if (accept) begin
				sel_q        <= AW'(req.entry_index);
				sel_hit_q    <= 1'b0;
				res_entry_q  <= req.entry_index;
				res_hit_q    <= 1'b0;
				res_need_q   <= 1'b0;
				res_status_q <= bbc_pkg::STAT_OK;
			end
			if (state_q == bbc_pkg::S_PICK) begin
				sel_hit_q <= hit_found_q;
				if (hit_found_q) begin
					sel_q <= hit_idx_q;
				end else if (bb_found_q) begin
					sel_q <= bb_idx_q;
				end else begin
					sel_q <= ab_idx_q;
				end
				res_entry_q  <= '0;
				res_hit_q    <= 1'b0;
				res_need_q   <= 1'b0;
				res_status_q <= bbc_pkg::STAT_NO_FREE;
			end
			if (state_q == bbc_pkg::S_UPDATE) begin
				res_entry_q  <= bbc_pkg::IDX_W'(sel_q);
				res_hit_q    <= u_hit;
				res_need_q   <= u_need;
				res_status_q <= u_status;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			rsp_entry_q  <= '0;
			rsp_hit_q    <= 1'b0;
			rsp_need_q   <= 1'b0;
			rsp_status_q <= bbc_pkg::STAT_OK;
		end else if (out_load) begin
			rsp_valid_q  <= 1'b1;
			rsp_entry_q  <= res_entry_q;
			rsp_hit_q    <= res_hit_q;
			rsp_need_q   <= res_need_q;
			rsp_status_q <= res_status_q;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.entry_out  = rsp_entry_q;
	assign rsp.was_hit    = rsp_hit_q;
	assign rsp.needs_read = rsp_need_q;
	assign rsp.status     = rsp_status_q;

endmodule

`default_nettype wire

FILE: rtl/bbc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/bbc_mod.sv
// Bucket hash unit: block number modulo the bucket count, several bits per cycle.
// Depends on bbc_pkg.
`default_nettype none

module bbc_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bbc_pkg::BLK_W-1:0]  value,
	output bbc_pkg::mod_stat_t         stat
);

	localparam int STEPS = bbc_pkg::BLK_W / bbc_pkg::MOD_STEP_BITS;
	localparam int CW    = $clog2(STEPS + 1);
	localparam logic [bbc_pkg::BKT_W:0] NB_V = (bbc_pkg::BKT_W + 1)'(bbc_pkg::NUM_BUCKETS);

	logic [bbc_pkg::BLK_W-1:0] word_q;
	logic [bbc_pkg::BKT_W-1:0] rem_q;
	logic [bbc_pkg::BKT_W-1:0] rem_n;
	logic [bbc_pkg::BKT_W:0]   trial;
	logic [CW-1:0]             left_q;
	logic                      done_q;

	always_comb begin
		rem_n = rem_q;
		trial = '0;
		for (int j = 0; j < bbc_pkg::MOD_STEP_BITS; j++) begin
			trial = {rem_n, word_q[bbc_pkg::BLK_W-1-j]};
			if (trial >= NB_V) begin
				trial = trial - NB_V;
			end
			rem_n = trial[bbc_pkg::BKT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			rem_q  <= '0;
			left_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			word_q <= value;
			rem_q  <= '0;
			left_q <= CW'(STEPS);
			done_q <= 1'b0;
		end else if (left_q != '0) begin
			word_q <= word_q << bbc_pkg::MOD_STEP_BITS;
			rem_q  <= rem_n;
			left_q <= left_q - 1'b1;
			done_q <= (left_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.done   = done_q;
	assign stat.bucket = rem_q;

endmodule

`default_nettype wire

FILE: rtl/bbc_checker.sv
// Port-level checker for the buffer cache tag manager, bound to the top level.
// Depends on bbc_pkg; watches the req and rsp channels only.
`default_nettype none

module bbc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  logic [bbc_pkg::IDX_W-1:0]     rsp_entry_out,
	input  logic                          rsp_was_hit,
	input  logic                          rsp_needs_read,
	input  logic [bbc_pkg::STATUS_W-1:0]  rsp_status
);

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (rsp_acc && !req_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("item accepted while previous item still at work");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result offered with no item outstanding");

	a_no_free_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == bbc_pkg::STAT_NO_FREE)
			|-> (rsp_entry_out == '0 && !rsp_was_hit && !rsp_needs_read))
		else $error("no-free result carries entry or flags");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_entry_out)
			&& $stable(rsp_status) && $stable(rsp_was_hit)))
		else $error("stalled result changed");

endmodule

bind block_buffer_cache_tags bbc_checker u_bbc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_entry_out  (rsp.entry_out),
	.rsp_was_hit    (rsp.was_hit),
	.rsp_needs_read (rsp.needs_read),
	.rsp_status     (rsp.status)
);

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for block_buffer_cache_tags: directed and random get/release/pin/unpin streams,
// with random idling on both channels and a long receiver hold-off, checked item by item
// against a local model of the tag state. Depends on bbc_pkg, bbc_req_if, bbc_rsp_if, RTL.

module tb_top;
	import bbc_pkg::*;

	localparam int PERIOD         = 4;
	localparam int STALL_MAX      = 18;
	localparam int DRAIN_CYCLES   = 60;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [IDX_W-1:0] entry;
		logic             hit;
		logic             need;
		status_t          status;
	} tag_result_t;

	logic clk;
	logic arst_n;

	bbc_req_if req_if();
	bbc_rsp_if rsp_if();

	block_buffer_cache_tags u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	logic [DEV_W-1:0]  mirror_dev   [NUM_ENTRIES];
	logic [BLK_W-1:0]  mirror_blk   [NUM_ENTRIES];
	logic              mirror_valid [NUM_ENTRIES];
	logic [CNT_W-1:0]  mirror_refs  [NUM_ENTRIES];
	logic [TIME_W-1:0] mirror_stamp [NUM_ENTRIES];

	tag_result_t pending_results[$];
	int          failures     = 0;
	int          quiet_cycles = 0;
	int          hold_left    = 0;
	bit          idle_on      = 1'b1;

	always #(PERIOD / 2) clk = ~clk;

	function automatic int oldest_free_entry(input bit in_bucket, input logic [BLK_W-1:0] bkt);
		int best;
		logic [TIME_W-1:0] best_stamp;
		best = -1;
		best_stamp = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (mirror_refs[i] != 0)
				continue;
			if (in_bucket && (mirror_blk[i] % NUM_BUCKETS) != bkt)
				continue;
			if (best < 0 || mirror_stamp[i] < best_stamp) begin
				best = i;
				best_stamp = mirror_stamp[i];
			end
		end
		return best;
	endfunction

	function automatic tag_result_t resolve_request(input op_t op, input logic [DEV_W-1:0] dev,
			input logic [BLK_W-1:0] blk, input logic [IDX_W-1:0] idx,
			input logic [TIME_W-1:0] now);
		tag_result_t r;
		int e;
		r = '0;
		r.status = STAT_OK;
		if (op == OP_GET) begin
			e = -1;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (e < 0 && mirror_dev[i] == dev && mirror_blk[i] == blk)
					e = i;
			end
			if (e >= 0) begin
				r.hit = 1'b1;
				if (mirror_refs[e] == COUNT_MAX)
					r.status = STAT_COUNT_ERR;
				else
					mirror_refs[e] = mirror_refs[e] + 1'b1;
			end else begin
				e = oldest_free_entry(1'b1, blk % NUM_BUCKETS);
				if (e < 0)
					e = oldest_free_entry(1'b0, '0);
				if (e >= 0) begin
					mirror_dev[e]   = dev;
					mirror_blk[e]   = blk;
					mirror_valid[e] = 1'b0;
					mirror_refs[e]  = CNT_W'(1);
				end
			end
			if (e < 0) begin
				r.status = STAT_NO_FREE;
			end else begin
				r.entry = IDX_W'(e);
				r.need = !mirror_valid[e];
				mirror_valid[e] = 1'b1;
			end
		end else begin
			r.entry = idx;
			if (int'(idx) < NUM_ENTRIES) begin
				if (op == OP_PIN) begin
					if (mirror_refs[idx] == COUNT_MAX)
						r.status = STAT_COUNT_ERR;
					else
						mirror_refs[idx] = mirror_refs[idx] + 1'b1;
				end else if (mirror_refs[idx] == 0) begin
					r.status = STAT_COUNT_ERR;
				end else begin
					mirror_refs[idx] = mirror_refs[idx] - 1'b1;
					if (op == OP_RELEASE && mirror_refs[idx] == 0)
						mirror_stamp[idx] = now;
				end
			end
		end
		return r;
	endfunction

	task automatic send_item(input op_t op, input logic [DEV_W-1:0] dev,
			input logic [BLK_W-1:0] blk, input logic [IDX_W-1:0] idx,
			input logic [TIME_W-1:0] now, output tag_result_t want);
		int gap;
		gap = idle_on ? $urandom_range(0, STALL_MAX) : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.op           <= op;
		req_if.device_id    <= dev;
		req_if.block_number <= blk;
		req_if.entry_index  <= idx;
		req_if.now_ticks    <= now;
		do @(posedge clk); while (!(req_if.valid && req_if.ready));
		want = resolve_request(op, dev, blk, idx, now);
		pending_results.push_back(want);
	endtask

	task automatic drop_all_refs();
		tag_result_t got;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			while (mirror_refs[i] != 0)
				send_item(OP_UNPIN, 8'($urandom()), $urandom(), IDX_W'(i), $urandom(), got);
		end
	endtask

	task automatic test_directed();
		tag_result_t got;
		send_item(OP_GET, 8'd0, 32'd0, 5'd0, 32'd0, got);
		send_item(OP_GET, 8'd0, 32'd0, 5'd31, '1, got);
		send_item(OP_RELEASE, 8'hFF, '1, 5'd0, 32'd100, got);
		send_item(OP_RELEASE, 8'd0, 32'd0, 5'd0, 32'd200, got);
		send_item(OP_RELEASE, 8'd0, 32'd0, 5'd0, 32'd300, got);
		send_item(OP_UNPIN, 8'd0, 32'd0, 5'd0, 32'd0, got);
		send_item(OP_PIN, 8'd0, 32'd0, 5'd31, 32'd0, got);
		send_item(OP_UNPIN, 8'd0, 32'd0, 5'd31, '1, got);
		send_item(OP_GET, 8'hFF, '1, 5'd0, 32'd0, got);
		send_item(OP_RELEASE, 8'd0, 32'd0, got.entry, '1, got);
		send_item(OP_GET, 8'd0, 32'd13, 5'd0, 32'd0, got);
		send_item(OP_RELEASE, 8'd0, 32'd0, got.entry, 32'd5, got);
		send_item(OP_GET, 8'd0, 32'd26, 5'd0, 32'd0, got);
		send_item(OP_RELEASE, 8'd0, 32'd0, got.entry, 32'd5, got);
		send_item(OP_GET, 8'd1, 32'd0, 5'd0, 32'd0, got);
		send_item(OP_RELEASE, 8'd0, 32'd0, got.entry, 32'd0, got);
		send_item(OP_GET, 8'hFF, '1, 5'd0, 32'd0, got);
		send_item(OP_PIN, 8'd0, 32'd0, got.entry, 32'd0, got);
		send_item(OP_UNPIN, 8'd0, 32'd0, got.entry, 32'd7, got);
		send_item(OP_RELEASE, 8'd0, 32'd0, got.entry, 32'hFFFF_FFFF, got);
	endtask

	task automatic test_no_free();
		tag_result_t got;
		drop_all_refs();
		for (int i = 0; i < NUM_ENTRIES; i++)
			send_item(OP_GET, 8'hA5, 32'h8000_0000 + i * 7, 5'd0, 32'd0, got);
		send_item(OP_GET, 8'h5A, 32'h1234_5678, 5'd0, 32'd0, got);
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			while (mirror_refs[i] != 0)
				send_item(OP_RELEASE, 8'd0, 32'd0, IDX_W'(i), $urandom_range(0, 3), got);
		end
	endtask

	task automatic test_count_saturation();
		tag_result_t got;
		logic [IDX_W-1:0] e;
		send_item(OP_GET, 8'h3C, 32'h0BAD_F00D, 5'd0, 32'd0, got);
		e = got.entry;
		while (mirror_refs[e] != COUNT_MAX)
			send_item(OP_PIN, 8'd0, 32'd0, e, 32'd0, got);
		send_item(OP_PIN, 8'd0, 32'd0, e, 32'd0, got);
		send_item(OP_GET, 8'h3C, 32'h0BAD_F00D, 5'd0, 32'd0, got);
		while (mirror_refs[e] != 0)
			send_item(OP_RELEASE, 8'd0, 32'd0, e, 32'h1000 + mirror_refs[e], got);
	endtask

	task automatic test_pressure();
		tag_result_t got;
		idle_on = 1'b0;
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 12; i++)
			send_item((i % 3 == 0) ? OP_PIN : OP_GET, 8'd2, 32'd40 + i, IDX_W'(i),
				$urandom(), got);
		drop_all_refs();
		idle_on = 1'b1;
	endtask

	task automatic test_random(input int count);
		int held[$];
		int sel;
		op_t op;
		logic [DEV_W-1:0] dev;
		logic [BLK_W-1:0] blk;
		logic [IDX_W-1:0] idx;
		logic [TIME_W-1:0] ticks;
		tag_result_t got;
		ticks = 32'd50;
		for (int k = 0; k < count; k++) begin
			idle_on = ((k / 150) % 3) != 2;
			held.delete();
			for (int i = 0; i < NUM_ENTRIES; i++)
				if (mirror_refs[i] != 0)
					held.push_back(i);
			sel = $urandom_range(0, 99);
			if (held.size() > 20)
				sel = 55 + sel % 45;
			case ($urandom_range(0, 19))
				0: ticks = $urandom();
				1: ;
				default: ticks = ticks + $urandom_range(1, 4);
			endcase
			dev = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0: blk = $urandom();
				1: blk = '1 - $urandom_range(0, 30);
				default: blk = $urandom_range(0, 40);
			endcase
			if (held.size() != 0 && $urandom_range(0, 9) < 8)
				idx = IDX_W'(held[$urandom_range(0, held.size() - 1)]);
			else
				idx = IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
			if (sel < 45)
				op = OP_GET;
			else if (sel < 55)
				op = OP_PIN;
			else if (sel < 80)
				op = OP_RELEASE;
			else
				op = OP_UNPIN;
			send_item(op, dev, blk, idx, ticks, got);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		tag_result_t want;
		int stall_left;
		rsp_if.ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected item: entry_out %0d status %0d",
						rsp_if.entry_out, rsp_if.status);
					failures++;
				end else begin
					want = pending_results.pop_front();
					if (rsp_if.entry_out !== want.entry) begin
						$error("entry_out: expected %0d, actual %0d", want.entry, rsp_if.entry_out);
						failures++;
					end
					if (rsp_if.was_hit !== want.hit) begin
						$error("was_hit: expected %0d, actual %0d", want.hit, rsp_if.was_hit);
						failures++;
					end
					if (rsp_if.needs_read !== want.need) begin
						$error("needs_read: expected %0d, actual %0d", want.need, rsp_if.needs_read);
						failures++;
					end
					if (rsp_if.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp_if.status);
						failures++;
					end
				end
				stall_left = idle_on ? $urandom_range(0, STALL_MAX) : 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		req_if.valid        = 1'b0;
		req_if.op           = OP_GET;
		req_if.device_id    = '0;
		req_if.block_number = '0;
		req_if.entry_index  = '0;
		req_if.now_ticks    = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			mirror_dev[i]   = '0;
			mirror_blk[i]   = '0;
			mirror_valid[i] = 1'b0;
			mirror_refs[i]  = '0;
			mirror_stamp[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_free();
		test_count_saturation();
		test_pressure();
		test_random(1150);
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
